### rtl/eight_bit_accumulator_cpu_core_defines.svh
// ---------------------------------------------------------------------------
// Eight-bit accumulator core assertion macros
// Shared property wrappers for the core's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef EIGHT_BIT_ACCUMULATOR_CPU_CORE_DEFINES_SVH
`define EIGHT_BIT_ACCUMULATOR_CPU_CORE_DEFINES_SVH

// same-cycle implication
`define EBAC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ebac assertion failed");

// next-cycle implication
`define EBAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ebac assertion failed");

`endif

### rtl/ebac_pkg.sv
// ---------------------------------------------------------------------------
// Eight-bit accumulator core package
// Payload types, memory sizing and arithmetic helpers.
// ---------------------------------------------------------------------------
package ebac_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int Q_DEPTH   = 2;

    localparam logic       FUNC_STEP = 1'b0;
    localparam logic       FUNC_LOAD = 1'b1;
    localparam logic       RC_OK     = 1'b0;
    localparam logic       RC_HALT   = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] load_address;
        logic [7:0]  load_data;
    } req_t;

    typedef struct packed {
        logic        result_code;
        logic [7:0]  acc_value;
        logic [7:0]  ext_value;
        logic [7:0]  status_value;
        logic [15:0] pointer_zero;
        logic [15:0] pointer_one;
        logic [15:0] pointer_two;
        logic [15:0] pointer_three;
        logic [31:0] tick_total;
    } rsp_t;

    typedef struct packed {
        logic        is_load;
        logic [15:0] addr;
        logic [7:0]  data;
    } q_t;

    function automatic logic [15:0] page_add(input logic [15:0] base,
                                             input logic [11:0] delta);
        page_add = {base[15:12], base[11:0] + delta};
    endfunction

    function automatic logic in_range(input logic [15:0] a);
        in_range = ({1'b0, a} < 17'(MEM_BYTES));
    endfunction

    // {carry, overflow, sum}
    function automatic logic [9:0] add_bin(input logic [7:0] a, input logic [7:0] b,
                                           input logic cin);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        add_bin = {s[8], (a[7] ^ s[7]) & (b[7] ^ s[7]), s[7:0]};
    endfunction

    // {carry, sum}
    function automatic logic [8:0] add_bcd(input logic [7:0] a, input logic [7:0] b,
                                           input logic cin);
        logic [4:0] lo;
        logic [4:0] hi;
        logic       cy;
        lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        hi = {1'b0, a[7:4]} + {1'b0, b[7:4]};
        cy = 1'b0;
        if (lo > 5'd9) begin
            lo = lo - 5'd10;
            hi = hi + 5'd1;
        end
        if (hi > 5'd9) begin
            hi = hi - 5'd10;
            cy = 1'b1;
        end
        add_bcd = {cy, hi[3:0], lo[3:0]};
    endfunction

endpackage

### rtl/ebac_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, registered read data.
// ---------------------------------------------------------------------------
module ebac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

### rtl/ebac_front.sv
// ---------------------------------------------------------------------------
// Eight-bit accumulator core front end
// Accepts request words, tags loads and steps, queues them for the back end.
// ---------------------------------------------------------------------------
`include "eight_bit_accumulator_cpu_core_defines.svh"

module ebac_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ebac_pkg::req_t  req,
    input  logic            busy,
    output logic            q_valid,
    output ebac_pkg::q_t    q_word,
    input  logic            q_pop
);

    localparam int CW = $clog2(ebac_pkg::Q_DEPTH + 1);
    localparam int PW = $clog2(ebac_pkg::Q_DEPTH);

    ebac_pkg::q_t   entry_reg [ebac_pkg::Q_DEPTH];
    logic [CW-1:0]  count_reg, count_next;
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic           push;

    assign req_ready  = (count_reg != CW'(ebac_pkg::Q_DEPTH)) && !busy;
    assign push       = req_valid && req_ready;
    assign q_valid    = (count_reg != '0);
    assign q_word     = entry_reg[rd_ptr_reg];
    assign count_next = count_reg + CW'(push) - CW'(q_pop && q_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= PW'((32'(wr_ptr_reg) + 1) % ebac_pkg::Q_DEPTH);
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= PW'((32'(rd_ptr_reg) + 1) % ebac_pkg::Q_DEPTH);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg].is_load <= (req.func == ebac_pkg::FUNC_LOAD);
            entry_reg[wr_ptr_reg].addr    <= req.load_address;
            entry_reg[wr_ptr_reg].data    <= req.load_data;
        end
    end

    `EBAC_ASSERT_NOW(a_no_push_full, count_reg == CW'(ebac_pkg::Q_DEPTH), !push)
    `EBAC_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(ebac_pkg::Q_DEPTH))
    `EBAC_ASSERT_NOW(a_no_push_busy, busy, !push)

endmodule

### rtl/ebac_exec.sv
// ---------------------------------------------------------------------------
// Eight-bit accumulator core back end
// Sequences fetch, displacement, operand and write-back on the byte memory.
// ---------------------------------------------------------------------------
`include "eight_bit_accumulator_cpu_core_defines.svh"

module ebac_exec (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  ebac_pkg::q_t                q_word,
    output logic                        q_pop,
    output logic                        busy,
    output logic                        ram_en,
    output logic                        ram_we,
    output logic [ebac_pkg::MEM_AW-1:0] ram_addr,
    output logic [7:0]                  ram_wdata,
    input  logic [7:0]                  ram_rdata,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output ebac_pkg::rsp_t              rsp
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_OP   = 3'd2;
    localparam logic [2:0] S_DISP = 3'd3;
    localparam logic [2:0] S_RMW  = 3'd4;
    localparam logic [2:0] S_MEM  = 3'd5;
    localparam int         AW     = ebac_pkg::MEM_AW;

    logic [2:0]     state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [7:0]     acc_reg, acc_next;
    logic [7:0]     ext_reg, ext_next;
    logic [7:0]     st_reg, st_next;
    logic [15:0]    ptr_reg [4];
    logic [15:0]    ptr_next [4];
    logic [31:0]    tick_reg, tick_next;
    logic           halt_reg, halt_next;
    logic [7:0]     op_reg, op_next;
    logic [15:0]    ea_reg, ea_next;
    logic           rd_ok_reg, rd_ok_next;
    logic           out_valid_reg;
    ebac_pkg::rsp_t out_reg;

    logic           out_free;
    logic           done;
    logic           code;
    logic [7:0]     rd_byte;
    logic [7:0]     op;
    logic [1:0]     pi;
    logic [15:0]    pc;
    logic [7:0]     dsel;
    logic [11:0]    disp;
    logic [15:0]    ea;
    logic [2:0]     alu;
    logic [7:0]     alu_acc;
    logic [7:0]     alu_st;
    logic [9:0]     bin_r;
    logic [8:0]     bcd_r;
    logic [7:0]     v;
    logic [15:0]    w;
    logic           go;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign busy      = (state_reg == S_CLR);
    assign rd_byte   = rd_ok_reg ? ram_rdata : 8'h00;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // memory-reference ALU, operand always from the last read
    assign alu   = op_reg[5:3];
    assign bin_r = ebac_pkg::add_bin(acc_reg, (alu == 3'd7) ? ~rd_byte : rd_byte, st_reg[7]);
    assign bcd_r = ebac_pkg::add_bcd(acc_reg, rd_byte, st_reg[7]);

    always_comb
    begin
        alu_acc = acc_reg;
        alu_st  = st_reg;
        case (alu)
            3'd0: alu_acc = rd_byte;
            3'd2: alu_acc = acc_reg & rd_byte;
            3'd3: alu_acc = acc_reg | rd_byte;
            3'd4: alu_acc = acc_reg ^ rd_byte;
            3'd5:
            begin
                alu_acc = bcd_r[7:0];
                alu_st  = {bcd_r[8], st_reg[6:0]};
            end
            3'd6, 3'd7:
            begin
                alu_acc = bin_r[7:0];
                alu_st  = {bin_r[9], bin_r[8], st_reg[5:0]};
            end
            default: alu_acc = acc_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        acc_next   = acc_reg;
        ext_next   = ext_reg;
        st_next    = st_reg;
        ptr_next   = ptr_reg;
        tick_next  = tick_reg;
        halt_next  = halt_reg;
        op_next    = op_reg;
        ea_next    = ea_reg;
        rd_ok_next = rd_ok_reg;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = clr_reg;
        ram_wdata  = 8'h00;
        q_pop      = 1'b0;
        done       = 1'b0;
        code       = ebac_pkg::RC_OK;
        op         = rd_byte;
        pi         = op_reg[1:0];
        pc         = ebac_pkg::page_add(ptr_reg[0], 12'd1);
        dsel       = (rd_byte == 8'h80) ? ext_reg : rd_byte;
        disp       = {{4{dsel[7]}}, dsel};
        ea         = ebac_pkg::page_add(ptr_reg[pi], disp);
        v          = 8'h00;
        w          = 16'h0000;
        go         = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_word.is_load)
                    begin
                        ram_en    = ebac_pkg::in_range(q_word.addr);
                        ram_we    = 1'b1;
                        ram_addr  = q_word.addr[AW-1:0];
                        ram_wdata = q_word.data;
                        done      = 1'b1;
                    end
                    else if (halt_reg)
                    begin
                        done = 1'b1;
                        code = ebac_pkg::RC_HALT;
                    end
                    else
                    begin
                        ptr_next[0] = pc;
                        ram_en      = ebac_pkg::in_range(pc);
                        ram_addr    = pc[AW-1:0];
                        rd_ok_next  = ebac_pkg::in_range(pc);
                        state_next  = S_OP;
                    end
                end
            end
            S_OP:
            begin
                if (out_free)
                begin
                    op_next   = op;
                    pi        = op[1:0];
                    tick_next = tick_reg + 32'd1;
                    if (!op[7])
                    begin
                        done       = 1'b1;
                        state_next = S_IDLE;
                        case (op)
                            8'h00: halt_next = 1'b1;
                            8'h01:
                            begin
                                acc_next = ext_reg;
                                ext_next = acc_reg;
                            end
                            8'h02: st_next = {1'b0, st_reg[6:0]};
                            8'h03: st_next = {1'b1, st_reg[6:0]};
                            8'h04: st_next = st_reg & 8'hF7;
                            8'h05: st_next = st_reg | 8'h08;
                            8'h06: acc_next = st_reg;
                            8'h07: st_next = (acc_reg & 8'hCF) | (st_reg & 8'h30);
                            8'h19: ext_next = {1'b0, ext_reg[7:1]};
                            8'h1C: acc_next = {1'b0, acc_reg[7:1]};
                            8'h1D: acc_next = {st_reg[7], acc_reg[7:1]};
                            8'h1E: acc_next = {acc_reg[0], acc_reg[7:1]};
                            8'h1F:
                            begin
                                acc_next = {st_reg[7], acc_reg[7:1]};
                                st_next  = {acc_reg[0], st_reg[6:0]};
                            end
                            8'h40: acc_next = ext_reg;
                            8'h50: acc_next = acc_reg & ext_reg;
                            8'h58: acc_next = acc_reg | ext_reg;
                            8'h60: acc_next = acc_reg ^ ext_reg;
                            8'h68:
                            begin
                                {st_next[7], acc_next} =
                                    ebac_pkg::add_bcd(acc_reg, ext_reg, st_reg[7]);
                            end
                            8'h70:
                            begin
                                {st_next[7], st_next[6], acc_next} =
                                    ebac_pkg::add_bin(acc_reg, ext_reg, st_reg[7]);
                            end
                            8'h78:
                            begin
                                {st_next[7], st_next[6], acc_next} =
                                    ebac_pkg::add_bin(acc_reg, ~ext_reg, st_reg[7]);
                            end
                            8'h30, 8'h31, 8'h32, 8'h33:
                            begin
                                acc_next     = ptr_reg[pi][7:0];
                                ptr_next[pi] = {ptr_reg[pi][15:8], acc_reg};
                            end
                            8'h34, 8'h35, 8'h36, 8'h37:
                            begin
                                acc_next     = ptr_reg[pi][15:8];
                                ptr_next[pi] = {acc_reg, ptr_reg[pi][7:0]};
                            end
                            8'h3C, 8'h3D, 8'h3E, 8'h3F:
                            begin
                                w            = ptr_reg[0];
                                ptr_next[0]  = ptr_reg[pi];
                                ptr_next[pi] = w;
                            end
                            default: acc_next = acc_reg;
                        endcase
                        code = halt_next;
                    end
                    else
                    begin
                        ptr_next[0] = pc;
                        ram_en      = ebac_pkg::in_range(pc);
                        ram_addr    = pc[AW-1:0];
                        rd_ok_next  = ebac_pkg::in_range(pc);
                        state_next  = S_DISP;
                    end
                end
            end
            S_DISP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    done       = 1'b1;
                    if (op_reg == 8'h8F)
                    begin
                        tick_next = tick_reg + 32'd13 + {23'd0, acc_reg, 1'b0}
                                  + {15'd0, rd_byte, 9'd0} + {23'd0, rd_byte, 1'b0};
                        acc_next  = 8'hFF;
                    end
                    else if (op_reg[7:4] == 4'h9)
                    begin
                        case (op_reg[3:2])
                            2'd0: go = 1'b1;
                            2'd1: go = !acc_reg[7];
                            2'd2: go = (acc_reg == 8'h00);
                            default: go = (acc_reg != 8'h00);
                        endcase
                        if (go)
                        begin
                            ptr_next[0] = ea;
                        end
                    end
                    else if ((op_reg & 8'hEC) == 8'hA8)
                    begin
                        done       = 1'b0;
                        ea_next    = ea;
                        ram_en     = ebac_pkg::in_range(ea);
                        ram_addr   = ea[AW-1:0];
                        rd_ok_next = ebac_pkg::in_range(ea);
                        state_next = S_RMW;
                    end
                    else if (op_reg >= 8'hC0)
                    begin
                        if (op_reg[2] && (pi == 2'd0))
                        begin
                            if (alu != 3'd1)
                            begin
                                acc_next = alu_acc;
                                st_next  = alu_st;
                            end
                        end
                        else
                        begin
                            if (op_reg[2])
                            begin
                                if (dsel[7])
                                begin
                                    ptr_next[pi] = ea;
                                end
                                else
                                begin
                                    ea           = ptr_reg[pi];
                                    ptr_next[pi] = ebac_pkg::page_add(ptr_reg[pi], disp);
                                end
                            end
                            ram_addr = ea[AW-1:0];
                            if (alu == 3'd1)
                            begin
                                ram_en    = ebac_pkg::in_range(ea);
                                ram_we    = 1'b1;
                                ram_wdata = acc_reg;
                            end
                            else
                            begin
                                done       = 1'b0;
                                ram_en     = ebac_pkg::in_range(ea);
                                rd_ok_next = ebac_pkg::in_range(ea);
                                state_next = S_MEM;
                            end
                        end
                    end
                end
            end
            S_RMW:
            begin
                if (out_free)
                begin
                    v          = op_reg[4] ? rd_byte - 8'd1 : rd_byte + 8'd1;
                    ram_en     = ebac_pkg::in_range(ea_reg);
                    ram_we     = 1'b1;
                    ram_addr   = ea_reg[AW-1:0];
                    ram_wdata  = v;
                    acc_next   = v;
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MEM:
            begin
                if (out_free)
                begin
                    acc_next   = alu_acc;
                    st_next    = alu_st;
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            acc_reg       <= 8'h00;
            ext_reg       <= 8'h00;
            st_reg        <= 8'h00;
            for (int i = 0; i < 4; i++)
            begin
                ptr_reg[i] <= 16'h0000;
            end
            tick_reg      <= 32'd0;
            halt_reg      <= 1'b0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            acc_reg   <= acc_next;
            ext_reg   <= ext_next;
            st_reg    <= st_next;
            ptr_reg   <= ptr_next;
            tick_reg  <= tick_next;
            halt_reg  <= halt_next;
            rd_ok_reg <= rd_ok_next;
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        ea_reg <= ea_next;
        if (done)
        begin
            out_reg.result_code   <= code;
            out_reg.acc_value     <= acc_next;
            out_reg.ext_value     <= ext_next;
            out_reg.status_value  <= st_next;
            out_reg.pointer_zero  <= ptr_next[0];
            out_reg.pointer_one   <= ptr_next[1];
            out_reg.pointer_two   <= ptr_next[2];
            out_reg.pointer_three <= ptr_next[3];
            out_reg.tick_total    <= tick_next;
        end
    end

    `EBAC_ASSERT_NOW(a_clr_quiet, state_reg == S_CLR, !out_valid_reg && !q_pop)
    `EBAC_ASSERT_NEXT(a_halt_sticks, halt_reg, halt_reg)
    `EBAC_ASSERT_NEXT(a_fetch_page, state_reg == S_OP && out_free && op[7],
        ptr_reg[0][15:12] == $past(ptr_reg[0][15:12]))
    `EBAC_ASSERT_NOW(a_done_slot, done, out_free)

endmodule

### rtl/eight_bit_accumulator_cpu_core.sv
// ---------------------------------------------------------------------------
// Eight-bit accumulator CPU core
// Front queue, execution sequencer and byte memory.
// ---------------------------------------------------------------------------
// channel | signals                     | word
// req     | req_valid, req_ready, req   | step or byte load
// rsp     | rsp_valid, rsp_ready, rsp   | registers after the word
//
// Load and halted step finish in S_IDLE. One-byte opcode: fetch, then S_OP.
// Two-byte opcode: S_DISP, then S_MEM or S_RMW for an operand read (single port).
// After reset the memory is zeroed, one byte a cycle, all 65536 bytes; no words taken.
// A stalled rsp holds the sequencer at its next result; req keeps queueing until the two-entry queue is full.
// ---------------------------------------------------------------------------
module eight_bit_accumulator_cpu_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ebac_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ebac_pkg::rsp_t rsp
);

    logic                        busy;
    logic                        q_valid;
    logic                        q_pop;
    ebac_pkg::q_t                q_word;
    logic                        ram_en;
    logic                        ram_we;
    logic [ebac_pkg::MEM_AW-1:0] ram_addr;
    logic [7:0]                  ram_wdata;
    logic [7:0]                  ram_rdata;

    ebac_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .busy      (busy),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_pop     (q_pop)
    );

    ebac_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_pop     (q_pop),
        .busy      (busy),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    ebac_ram #(
        .WIDTH (8),
        .DEPTH (ebac_pkg::MEM_BYTES)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule
